[sv/bmw_pkg.sv]
// Shared types and constants for the binary morphology window block.
// Used by every module of the block except bmw_ram; has no dependencies of its own.
`default_nettype none

package bmw_pkg;

    // Structuring element geometry.
    localparam int ELEM_SIZE  = 5;
    localparam int HALF       = ELEM_SIZE / 2;
    localparam int WIN_BITS   = ELEM_SIZE * ELEM_SIZE;
    localparam int STACK_BITS = ELEM_SIZE - 1;

    // Field and register widths.
    localparam int PIXEL_W     = 8;
    localparam int MODE_W      = 2;
    localparam int SIZE_W      = 11;
    localparam int CFG_DATA_W  = 25;
    localparam int CFG_INDEX_W = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASK   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd3;

    // Operating modes; the unused code behaves as dilation.
    localparam logic [MODE_W-1:0] MODE_DILATE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ERODE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOUNDARY = 2'd2;

    // Pixel values and register reset values.
    localparam logic [PIXEL_W-1:0]  PIXEL_BLACK = 8'd0;
    localparam logic [PIXEL_W-1:0]  PIXEL_WHITE = 8'd255;
    localparam logic [WIN_BITS-1:0] MASK_RESET  = 25'd4357252;
    localparam logic [SIZE_W-1:0]   SIZE_RESET  = 11'd1024;

    // Per-item control that travels with a pixel down the pipeline.
    typedef struct packed {
        logic                  has_out;
        logic                  last;
        logic [ELEM_SIZE-1:0]  row_ok;
        logic [ELEM_SIZE-1:0]  col_ok;
        logic [MODE_W-1:0]     mode;
        logic [WIN_BITS-1:0]   mask;
    } item_ctrl_t;

endpackage

`default_nettype wire

[sv/bmw_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by the binary morphology window for its line stack.
`default_nettype none

module bmw_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/bmw_frame_ctrl.sv]
// Configuration registers, frame tracking and per-item position logic.
// Depends on bmw_pkg for widths, register indexes and the item control struct.
`default_nettype none

module bmw_frame_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [bmw_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [bmw_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                 take,
    input  wire logic                                 pad,
    output logic                                      load,
    output logic [$clog2(MAX_WIDTH)-1:0]              rd_col,
    output bmw_pkg::item_ctrl_t                       item
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int LW = $clog2(bmw_pkg::HALF * MAX_WIDTH + bmw_pkg::HALF + 1);

    // Software-visible registers.
    logic [bmw_pkg::MODE_W-1:0]   mode_reg;
    logic [bmw_pkg::WIN_BITS-1:0] mask_reg;
    logic [bmw_pkg::SIZE_W-1:0]   width_reg;
    logic [bmw_pkg::SIZE_W-1:0]   height_reg;

    // Frame state.
    logic                         active_reg;
    logic [bmw_pkg::MODE_W-1:0]   act_mode_reg;
    logic [bmw_pkg::WIN_BITS-1:0] act_mask_reg;
    logic [WW-1:0]                w_reg;
    logic [HW-1:0]                h_reg;
    logic [LW-1:0]                lag_reg;
    logic [CW-1:0]                in_col_reg;
    logic [LW-1:0]                lead_reg;
    logic [HW-1:0]                out_row_reg;
    logic [CW-1:0]                out_col_reg;

    logic                         start;
    logic [WW-1:0]                w_clamp;
    logic [HW-1:0]                h_clamp;
    logic [WW-1:0]                w_eff;
    logic [HW-1:0]                h_eff;
    logic [LW-1:0]                lag_eff;
    logic [CW-1:0]                in_col_eff;
    logic [LW-1:0]                lead_eff;
    logic [HW-1:0]                out_row_eff;
    logic [CW-1:0]                out_col_eff;
    logic                         has_out;
    logic                         last;
    logic [WW:0]                  col_inc;
    logic [WW:0]                  out_col_inc;
    logic [HW:0]                  out_row_inc;
    logic [CW-1:0]                in_col_next;
    logic [LW-1:0]                lead_next;
    logic                         out_col_wrap;
    logic [HW+1:0]                row_sum;
    logic [WW+1:0]                col_sum;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        start = !active_reg;

        // Saturate the programmed sizes into 1..MAX.
        if (width_reg == '0)
        begin
            w_clamp = WW'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_clamp = WW'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = WW'(width_reg);
        end

        if (height_reg == '0)
        begin
            h_clamp = HW'(1);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            h_clamp = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_clamp = HW'(height_reg);
        end

        w_eff       = start ? w_clamp : w_reg;
        h_eff       = start ? h_clamp : h_reg;
        lag_eff     = start ? LW'(w_clamp) * LW'(bmw_pkg::HALF) + LW'(bmw_pkg::HALF)
                            : lag_reg;
        in_col_eff  = start ? '0 : in_col_reg;
        lead_eff    = start ? '0 : lead_reg;
        out_row_eff = start ? '0 : out_row_reg;
        out_col_eff = start ? '0 : out_col_reg;

        load    = take && !(start && pad);
        has_out = (lead_eff == lag_eff);

        out_col_inc  = (WW+1)'(out_col_eff) + (WW+1)'(1);
        out_row_inc  = (HW+1)'(out_row_eff) + (HW+1)'(1);
        out_col_wrap = (out_col_inc == (WW+1)'(w_eff));
        last         = has_out && out_col_wrap && (out_row_inc == (HW+1)'(h_eff));

        col_inc     = (WW+1)'(in_col_eff) + (WW+1)'(1);
        in_col_next = (col_inc == (WW+1)'(w_eff)) ? '0 : CW'(col_inc);
        lead_next   = has_out ? lead_eff : lead_eff + LW'(1);

        rd_col = in_col_eff;

        // Which window rows and columns fall inside the image for this result.
        item.row_ok = '0;
        item.col_ok = '0;
        row_sum     = '0;
        col_sum     = '0;
        for (int j = 0; j < bmw_pkg::ELEM_SIZE; j++)
        begin
            row_sum = (HW+2)'(out_row_eff) + (HW+2)'(j);
            item.row_ok[j] = (row_sum >= (HW+2)'(bmw_pkg::HALF)) &&
                             (row_sum < (HW+2)'(h_eff) + (HW+2)'(bmw_pkg::HALF));
            col_sum = (WW+2)'(out_col_eff) + (WW+2)'(j);
            item.col_ok[j] = (col_sum >= (WW+2)'(bmw_pkg::HALF)) &&
                             (col_sum < (WW+2)'(w_eff) + (WW+2)'(bmw_pkg::HALF));
        end

        item.has_out = has_out;
        item.last    = last;
        item.mode    = start ? mode_reg : act_mode_reg;
        item.mask    = start ? mask_reg : act_mask_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= bmw_pkg::MODE_DILATE;
            mask_reg     <= bmw_pkg::MASK_RESET;
            width_reg    <= bmw_pkg::SIZE_RESET;
            height_reg   <= bmw_pkg::SIZE_RESET;
            active_reg   <= 1'b0;
            act_mode_reg <= bmw_pkg::MODE_DILATE;
            act_mask_reg <= '0;
            w_reg        <= WW'(1);
            h_reg        <= HW'(1);
            lag_reg      <= '0;
            in_col_reg   <= '0;
            lead_reg     <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    bmw_pkg::CFG_MODE:   mode_reg   <= cfg_data[bmw_pkg::MODE_W-1:0];
                    bmw_pkg::CFG_MASK:   mask_reg   <= cfg_data[bmw_pkg::WIN_BITS-1:0];
                    bmw_pkg::CFG_WIDTH:  width_reg  <= cfg_data[bmw_pkg::SIZE_W-1:0];
                    bmw_pkg::CFG_HEIGHT: height_reg <= cfg_data[bmw_pkg::SIZE_W-1:0];
                    default: ;
                endcase
            end

            if (load)
            begin
                active_reg <= !last;
                if (start)
                begin
                    act_mode_reg <= mode_reg;
                    act_mask_reg <= mask_reg;
                    w_reg        <= w_clamp;
                    h_reg        <= h_clamp;
                    lag_reg      <= lag_eff;
                end
                in_col_reg <= in_col_next;
                lead_reg   <= lead_next;
                if (has_out)
                begin
                    out_col_reg <= out_col_wrap ? '0 : CW'(out_col_inc);
                    out_row_reg <= out_col_wrap ? HW'(out_row_inc) : out_row_eff;
                end
                else
                begin
                    out_col_reg <= out_col_eff;
                    out_row_reg <= out_row_eff;
                end
            end
        end
    end

endmodule

`default_nettype wire

[sv/bmw_kernel.sv]
// Result logic: applies the structuring element to one 5x5 window of black flags.
// Depends on bmw_pkg for the window geometry, mode codes and item control struct.
`default_nettype none

module bmw_kernel (
    input  wire logic [bmw_pkg::WIN_BITS-1:0] window,
    input  wire bmw_pkg::item_ctrl_t          item,
    output logic                              black
);

    logic [bmw_pkg::WIN_BITS-1:0] in_img;
    logic [bmw_pkg::WIN_BITS-1:0] blk;
    logic [bmw_pkg::WIN_BITS-1:0] reflected;
    logic                         center;
    logic                         eroded_white;
    logic                         dilated;

    always_comb
    begin
        for (int j = 0; j < bmw_pkg::ELEM_SIZE; j++)
        begin
            for (int k = 0; k < bmw_pkg::ELEM_SIZE; k++)
            begin
                in_img[j*bmw_pkg::ELEM_SIZE + k] = item.row_ok[j] & item.col_ok[k];
            end
        end

        // Dilation uses the element mirrored through its center.
        for (int i = 0; i < bmw_pkg::WIN_BITS; i++)
        begin
            reflected[bmw_pkg::WIN_BITS-1-i] = item.mask[i];
        end

        blk          = window & in_img;
        center       = blk[bmw_pkg::HALF*bmw_pkg::ELEM_SIZE + bmw_pkg::HALF];
        eroded_white = !center || (|(in_img & ~blk & item.mask));
        dilated      = |(blk & reflected);

        case (item.mode)
            bmw_pkg::MODE_ERODE:    black = !eroded_white;
            bmw_pkg::MODE_BOUNDARY: black = center && eroded_white;
            default:                black = dilated;
        endcase
    end

endmodule

`default_nettype wire

[sv/binary_morphology_window.sv]
// Top level of the streaming 5x5 binary morphology block.
// Depends on bmw_pkg, bmw_ram, bmw_frame_ctrl and bmw_kernel.
`default_nettype none

// The block takes a binary image in raster order, one pixel per word, and
// returns one result pixel (0 black or 255 white) for each image pixel,
// computed by dilation, erosion or boundary extraction with a programmable
// 5x5 structuring element; neighbors outside the image are ignored. It
// accepts one word every clock cycle unless the result stream stalls, and
// returns at most one result word per cycle. A result leaves 2*W+2 accepted
// words after its own pixel, where W is the image width, because the window
// must span two rows below it; after the last pixel of a frame the source
// sends that many padding words (tuser set) to drain the window, and the
// final result carries tlast. An accepted word reaches the result it
// releases through the input register, where the column of four earlier
// rows is read from a MAX_WIDTH by 4-bit line memory, the window register
// and the output register. The line memory is written and read once per
// word, which holds the rate at one word per clock unless stalled. The frame
// starts on the first pixel word seen while idle; the four registers are
// sampled at that moment, so writes during a frame take effect on the next
// one, and padding words seen while idle are dropped. The configuration
// channel is always ready.
module binary_morphology_window #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Pixel input stream.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // [7:0] pixel
    input  wire logic                                s_tuser,   // [0] is_padding
    // Result stream.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [7:0]                               m_tdata,   // [7:0] out_pixel
    output logic                                     m_tlast,
    // Register write channel.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bmw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [bmw_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int ES = bmw_pkg::ELEM_SIZE;
    localparam int SB = bmw_pkg::STACK_BITS;

    logic                         accept;
    logic                         load;
    logic [CW-1:0]                rd_col;
    bmw_pkg::item_ctrl_t          item;

    // Input stage: the pixel's black flag while its column stack is read.
    logic                         a_valid_reg;
    logic                         a_valid_next;
    logic                         a_black_reg;
    logic [CW-1:0]                a_col_reg;
    bmw_pkg::item_ctrl_t          a_ctrl_reg;
    logic                         a_byp_reg;
    logic [SB-1:0]                a_byp_data_reg;
    logic                         a_adv;

    // Window stage.
    logic                         b_valid_reg;
    logic                         b_valid_next;
    logic [bmw_pkg::WIN_BITS-1:0] win_reg;
    logic [bmw_pkg::WIN_BITS-1:0] win_next;
    bmw_pkg::item_ctrl_t          b_ctrl_reg;
    logic                         b_adv;

    // Output stage.
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [bmw_pkg::PIXEL_W-1:0]  m_data_reg;
    logic                         m_last_reg;
    logic                         out_free;

    logic [SB-1:0]                ram_rdata;
    logic [SB-1:0]                stack;
    logic [SB-1:0]                stack_wr;
    logic [ES-1:0]                column;
    logic                         res_black;

    assign accept = s_tvalid && s_tready;

    bmw_frame_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_frame_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (accept),
        .pad       (s_tuser),
        .load      (load),
        .rd_col    (rd_col),
        .item      (item)
    );

    // Each entry holds the black flags of the four rows above the current
    // one at that column, newest row in bit 0. Every word, including
    // padding, pushes its flag in so that drained rows keep their history.
    bmw_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (a_adv),
        .waddr (a_col_reg),
        .wdata (stack_wr),
        .re    (load),
        .raddr (rd_col),
        .rdata (ram_rdata)
    );

    // Handshake: each stage moves on when the one after it is empty or
    // moving; items with no result never wait for the output register.
    always_comb
    begin
        out_free = !m_valid_reg || m_tready;
        b_adv    = b_valid_reg && (!b_ctrl_reg.has_out || out_free);
        a_adv    = a_valid_reg && (!b_valid_reg || b_adv);
        s_tready = !a_valid_reg || a_adv;

        a_valid_next = load ? 1'b1 : (a_adv ? 1'b0 : a_valid_reg);
        b_valid_next = a_adv ? 1'b1 : (b_adv ? 1'b0 : b_valid_reg);
        if (b_adv && b_ctrl_reg.has_out)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    // A one-pixel-wide image reads the entry that the previous word is
    // writing in the same cycle, so that write is forwarded.
    always_comb
    begin
        stack    = a_byp_reg ? a_byp_data_reg : ram_rdata;
        stack_wr = {stack[SB-2:0], a_black_reg};

        column[ES-1] = a_black_reg;
        for (int j = 0; j < ES - 1; j++)
        begin
            column[j] = stack[ES-2-j];
        end

        for (int j = 0; j < ES; j++)
        begin
            for (int k = 0; k < ES - 1; k++)
            begin
                win_next[j*ES + k] = win_reg[j*ES + k + 1];
            end
            win_next[j*ES + ES - 1] = column[j];
        end
    end

    bmw_kernel u_kernel (
        .window (win_reg),
        .item   (b_ctrl_reg),
        .black  (res_black)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_black_reg    <= !s_tuser && (s_tdata == bmw_pkg::PIXEL_BLACK);
            a_col_reg      <= rd_col;
            a_ctrl_reg     <= item;
            a_byp_reg      <= a_adv && (a_col_reg == rd_col);
            a_byp_data_reg <= stack_wr;
        end
        if (a_adv)
        begin
            win_reg    <= win_next;
            b_ctrl_reg <= a_ctrl_reg;
        end
        if (b_adv && b_ctrl_reg.has_out)
        begin
            m_data_reg <= res_black ? bmw_pkg::PIXEL_BLACK : bmw_pkg::PIXEL_WHITE;
            m_last_reg <= b_ctrl_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire
